### rtl/sfsu_pkg.sv
// shared types and constants for the sensor fifo sample unpacker
package sfsu_pkg;

	// default depth of the sample ring
	localparam int DEF_RING_DEPTH = 4;

	// field widths
	localparam int PTR_W     = 5;
	localparam int VALUE_W   = 18;
	localparam int PARTIAL_W = 16;
	localparam int BYTES_W   = 8;
	localparam int LEDS_W    = 2;
	localparam int PHASE_W   = 3;

	// bytes per 18-bit value
	localparam int BYTES_PER_VALUE = 3;

	// request modes
	localparam logic [1:0] MODE_DATA     = 2'd0;
	localparam logic [1:0] MODE_ADVANCE  = 2'd1;
	localparam logic [1:0] MODE_POINTERS = 2'd2;

	// led register codes
	localparam logic [LEDS_W-1:0] LEDS_RED_ONLY = 2'd1;
	localparam logic [LEDS_W-1:0] LEDS_RESET    = 2'd2;

	// byte position within one red/ir sample
	localparam logic [PHASE_W-1:0] PH_RED0 = 3'd0;
	localparam logic [PHASE_W-1:0] PH_RED1 = 3'd1;
	localparam logic [PHASE_W-1:0] PH_RED2 = 3'd2;
	localparam logic [PHASE_W-1:0] PH_IR0  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_IR1  = 3'd4;
	localparam logic [PHASE_W-1:0] PH_IR2  = 3'd5;

	// ring updates for one request
	typedef struct packed {
		logic               write_red;
		logic               write_ir;
		logic               adv_tail;
		logic [VALUE_W-1:0] value;
	} ring_ctrl_t;

endpackage

### rtl/sfsu_ring.sv
// sample ring: red/ir slots with head and tail indexes
module sfsu_ring #(
	parameter int RING_DEPTH = sfsu_pkg::DEF_RING_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfsu_pkg::ring_ctrl_t         ctrl,
	output logic [sfsu_pkg::VALUE_W-1:0] red_view,
	output logic [sfsu_pkg::VALUE_W-1:0] ir_view,
	output logic [1:0]                   avail_view
);
	import sfsu_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_W  = (IDX_W+1)'(RING_DEPTH);

	logic [VALUE_W-1:0] red_q [RING_DEPTH];
	logic [VALUE_W-1:0] ir_q  [RING_DEPTH];
	logic [IDX_W-1:0]   head_q, tail_q;
	logic [IDX_W-1:0]   head_d, tail_d;
	logic [IDX_W:0]     avail_full;

	function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + 1'b1;
	endfunction

	assign head_d = ctrl.write_red ? idx_inc(head_q) : head_q;
	// tail only moves when something is available
	assign tail_d = (ctrl.adv_tail && (head_q != tail_q)) ? idx_inc(tail_q) : tail_q;

	assign avail_full = {1'b0, head_d} + ((head_d < tail_d) ? DEPTH_W : '0) - {1'b0, tail_d};
	assign avail_view = avail_full[1:0];

	assign red_view = ctrl.write_red ? ctrl.value : red_q[head_d];
	assign ir_view  = ctrl.write_ir  ? ctrl.value : ir_q[head_d];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			for (int i = 0; i < RING_DEPTH; i++) begin
				red_q[i] <= '0;
				ir_q[i]  <= '0;
			end
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			if (ctrl.write_red) begin
				red_q[head_d] <= ctrl.value;
			end
			if (ctrl.write_ir) begin
				ir_q[head_q] <= ctrl.value;
			end
		end
	end

endmodule

### rtl/sensor_fifo_sample_unpacker.sv
// top level: byte assembly, pointer math and request/result handshakes
//
// Usage:
//   Input channel (in_valid/in_stall) carries one request: mode, data_byte,
//   read_pointer, write_pointer. Mode 0 feeds one sensor FIFO byte, mode 1
//   releases the oldest ring sample, mode 2 gives the FIFO pointer pair and
//   restarts byte assembly. Every request gives exactly one result on the
//   output channel (out_valid/out_stall): sample_done, the head slot's red
//   and ir values, the available count, and in mode 2 the new sample and
//   byte counts.
//   The edge that accepts a request loads the input register; the result
//   register is then loaded from the assembly/ring update logic once it can
//   advance, and out_valid rises with it.
//   Throughput is one request per cycle, limited only by the result register.
//   When the receiver holds out_stall the result stays put; one more request
//   is held in the input register and then in_stall rises.
//   Reset clears the ring, head, tail and byte phase and sets active_leds to
//   two. The active_leds register is written over cfg_valid/cfg_ready, which
//   is always ready; write it only while no request is in flight.
module sensor_fifo_sample_unpacker #(
	parameter int RING_DEPTH = sfsu_pkg::DEF_RING_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sfsu_pkg::LEDS_W-1:0]    cfg_data,
	// requests
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     mode,
	input  logic [7:0]                     data_byte,
	input  logic [sfsu_pkg::PTR_W-1:0]     read_pointer,
	input  logic [sfsu_pkg::PTR_W-1:0]     write_pointer,
	// results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           sample_done,
	output logic [sfsu_pkg::VALUE_W-1:0]   latest_red,
	output logic [sfsu_pkg::VALUE_W-1:0]   latest_ir,
	output logic [1:0]                     available_count,
	output logic [sfsu_pkg::PTR_W-1:0]     new_samples,
	output logic [sfsu_pkg::BYTES_W-1:0]   bytes_to_read
);
	import sfsu_pkg::*;

	logic [LEDS_W-1:0]    leds_q;
	logic                 valid_s1;
	logic [1:0]           mode_s1;
	logic [7:0]           byte_s1;
	logic [PTR_W-1:0]     rp_s1, wp_s1;
	logic                 advance, move;

	logic [PHASE_W-1:0]   phase_q, phase_d;
	logic [PARTIAL_W-1:0] partial_q, partial_d;
	logic [1:0]           pos;
	logic                 ir_group;
	ring_ctrl_t           ctrl_raw, ctrl;
	logic                 done_d;
	logic [PTR_W-1:0]     ns_d;
	logic [BYTES_W-1:0]   nb_d;
	logic [BYTES_W:0]     nb_full;
	logic [BYTES_W:0]     mult;
	logic [VALUE_W-1:0]   red_view, ir_view;
	logic [1:0]           avail_view;

	logic                 out_valid_q, done_q;
	logic [VALUE_W-1:0]   red_q, ir_q;
	logic [1:0]           avail_q;
	logic [PTR_W-1:0]     ns_q;
	logic [BYTES_W-1:0]   nb_q;

	// handshake
	assign advance   = !out_valid_q || !out_stall;
	assign move      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leds_q <= LEDS_RESET;
		end else if (cfg_valid) begin
			leds_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1 <= mode;
			byte_s1 <= data_byte;
			rp_s1   <= read_pointer;
			wp_s1   <= write_pointer;
		end
	end

	always_comb begin
		pos      = 2'd0;
		ir_group = 1'b0;
		case (phase_q)
			PH_RED0: pos = 2'd0;
			PH_RED1: pos = 2'd1;
			PH_RED2: pos = 2'd2;
			PH_IR0: begin
				pos      = 2'd0;
				ir_group = 1'b1;
			end
			PH_IR1: begin
				pos      = 2'd1;
				ir_group = 1'b1;
			end
			PH_IR2: begin
				pos      = 2'd2;
				ir_group = 1'b1;
			end
			default: begin
				pos      = 2'd0;
				ir_group = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d   = phase_q;
		partial_d = partial_q;
		ctrl_raw  = '0;
		done_d    = 1'b0;
		ns_d      = '0;
		nb_d      = '0;
		mult      = (leds_q == LEDS_RED_ONLY) ? (BYTES_W+1)'(BYTES_PER_VALUE)
		                                      : (BYTES_W+1)'(2 * BYTES_PER_VALUE);
		nb_full   = '0;
		case (mode_s1)
			MODE_DATA: begin
				case (pos)
					2'd0: begin
						partial_d = {byte_s1, 8'h00};
						phase_d   = ir_group ? PH_IR1 : PH_RED1;
					end
					2'd1: begin
						partial_d = {partial_q[15:8], byte_s1};
						phase_d   = ir_group ? PH_IR2 : PH_RED2;
					end
					default: begin
						ctrl_raw.value = {partial_q[VALUE_W-9:0], byte_s1};
						if (!ir_group) begin
							ctrl_raw.write_red = 1'b1;
							if (leds_q == LEDS_RED_ONLY) begin
								done_d  = 1'b1;
								phase_d = PH_RED0;
							end else begin
								phase_d = PH_IR0;
							end
						end else begin
							ctrl_raw.write_ir = 1'b1;
							done_d            = 1'b1;
							phase_d           = PH_RED0;
						end
					end
				endcase
			end
			MODE_ADVANCE: begin
				ctrl_raw.adv_tail = 1'b1;
			end
			MODE_POINTERS: begin
				// pointer difference wraps with the 5-bit fifo pointers
				ns_d      = wp_s1 - rp_s1;
				nb_full   = (BYTES_W+1)'(ns_d) * mult;
				nb_d      = nb_full[BYTES_W] ? '1 : nb_full[BYTES_W-1:0];
				phase_d   = PH_RED0;
				partial_d = '0;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	assign ctrl = move ? ctrl_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_RED0;
			partial_q <= '0;
		end else if (move) begin
			phase_q   <= phase_d;
			partial_q <= partial_d;
		end
	end

	sfsu_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.red_view  (red_view),
		.ir_view   (ir_view),
		.avail_view(avail_view)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			done_q  <= done_d;
			red_q   <= red_view;
			ir_q    <= ir_view;
			avail_q <= avail_view;
			ns_q    <= ns_d;
			nb_q    <= nb_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_done     = done_q;
	assign latest_red      = red_q;
	assign latest_ir       = ir_q;
	assign available_count = avail_q;
	assign new_samples     = ns_q;
	assign bytes_to_read   = nb_q;

endmodule

### rtl/sfsu_checker.sv
// port-level checks for the sensor fifo sample unpacker, bound to the top level
module sfsu_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           sample_done,
	input logic [sfsu_pkg::VALUE_W-1:0]   latest_red,
	input logic [sfsu_pkg::PTR_W-1:0]     new_samples,
	input logic [sfsu_pkg::BYTES_W-1:0]   bytes_to_read
);
	import sfsu_pkg::*;

	logic [BYTES_W:0] ns_x3, ns_x6;

	assign ns_x3 = (BYTES_W+1)'(new_samples) * (BYTES_W+1)'(BYTES_PER_VALUE);
	assign ns_x6 = (BYTES_W+1)'(new_samples) * (BYTES_W+1)'(2 * BYTES_PER_VALUE);

	// a stalled result stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(latest_red) && $stable(bytes_to_read))
		else $error("stalled result changed");

	// pointer requests never finish a sample
	a_done_no_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_done |-> new_samples == '0 && bytes_to_read == '0)
		else $error("sample done together with pointer counts");

	// byte count is three or six bytes per sample
	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, bytes_to_read} == ns_x3 || {1'b0, bytes_to_read} == ns_x6)
		else $error("byte count does not match sample count");

endmodule

bind sensor_fifo_sample_unpacker sfsu_checker u_sfsu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.sample_done  (sample_done),
	.latest_red   (latest_red),
	.new_samples  (new_samples),
	.bytes_to_read(bytes_to_read)
);

### tb/sv/tb_top.sv
// testbench for the sensor fifo sample unpacker: random requests checked against a local predictor
module tb_top;
	import sfsu_pkg::*;

	localparam logic [1:0]        MODE_UNUSED = 2'd3;
	localparam logic [LEDS_W-1:0] LEDS_CODE0  = 2'd0;
	localparam logic [LEDS_W-1:0] LEDS_CODE3  = 2'd3;
	localparam int                IDLE_LIMIT  = 2000;
	localparam int                PHASE_ITEMS = 65;

	typedef struct {
		logic [1:0]       mode;
		logic [7:0]       data;
		logic [PTR_W-1:0] rp;
		logic [PTR_W-1:0] wp;
	} sensor_req_t;

	typedef struct {
		logic               done;
		logic [VALUE_W-1:0] red;
		logic [VALUE_W-1:0] ir;
		logic [1:0]         avail;
		logic [PTR_W-1:0]   nsamp;
		logic [BYTES_W-1:0] nbytes;
	} unpack_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [LEDS_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           mode = '0;
	logic [7:0]           data_byte = '0;
	logic [PTR_W-1:0]     read_pointer = '0;
	logic [PTR_W-1:0]     write_pointer = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 sample_done;
	logic [VALUE_W-1:0]   latest_red;
	logic [VALUE_W-1:0]   latest_ir;
	logic [1:0]           available_count;
	logic [PTR_W-1:0]     new_samples;
	logic [BYTES_W-1:0]   bytes_to_read;

	sensor_fifo_sample_unpacker i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.data_byte       (data_byte),
		.read_pointer    (read_pointer),
		.write_pointer   (write_pointer),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sample_done     (sample_done),
		.latest_red      (latest_red),
		.latest_ir       (latest_ir),
		.available_count (available_count),
		.new_samples     (new_samples),
		.bytes_to_read   (bytes_to_read)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sensor_req_t    pending_reqs[$];
	unpack_result_t expected_results[$];
	sensor_req_t    cur_req;
	int             send_gap = 0;
	int             stall_left = 0;
	int             idle_cycles = 0;
	int             mismatches = 0;
	bit             idle_on = 1'b1;

	// predictor state
	logic [LEDS_W-1:0]    leds_reg = LEDS_RESET;
	logic [PHASE_W-1:0]   asm_phase = PH_RED0;
	logic [PARTIAL_W-1:0] asm_partial = '0;
	logic [VALUE_W-1:0]   red_ring[DEF_RING_DEPTH] = '{default: '0};
	logic [VALUE_W-1:0]   ir_ring[DEF_RING_DEPTH] = '{default: '0};
	logic [1:0]           ring_head = '0;
	logic [1:0]           ring_tail = '0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	task automatic predict_unpack(input sensor_req_t r);
		unpack_result_t e;
		int             pos;
		bit             ir_grp;
		logic [23:0]    word;
		int             nb;
		e = '{default: '0};
		case (r.mode)
			MODE_DATA: begin
				pos = asm_phase % 3;
				ir_grp = (asm_phase >= PH_IR0);
				if (asm_phase > PH_IR2) begin
					pos = 0;
					ir_grp = 1'b0;
				end
				if (pos == 0) begin
					asm_partial = {r.data, 8'h00};
					asm_phase = ir_grp ? PH_IR1 : PH_RED1;
				end else if (pos == 1) begin
					asm_partial = {asm_partial[15:8], r.data};
					asm_phase = ir_grp ? PH_IR2 : PH_RED2;
				end else begin
					word = {asm_partial, r.data};
					if (!ir_grp) begin
						ring_head = ring_head + 2'd1;
						red_ring[ring_head] = word[VALUE_W-1:0];
						if (leds_reg == LEDS_RED_ONLY) begin
							e.done = 1'b1;
							asm_phase = PH_RED0;
						end else begin
							asm_phase = PH_IR0;
						end
					end else begin
						// ir group is closed as ir whatever the led count now says
						ir_ring[ring_head] = word[VALUE_W-1:0];
						e.done = 1'b1;
						asm_phase = PH_RED0;
					end
				end
			end
			MODE_ADVANCE: begin
				if (ring_head != ring_tail)
					ring_tail = ring_tail + 2'd1;
			end
			MODE_POINTERS: begin
				e.nsamp = r.wp - r.rp;
				nb = int'(e.nsamp) * ((leds_reg == LEDS_RED_ONLY) ? 1 : 2) * BYTES_PER_VALUE;
				e.nbytes = (nb > 255) ? 8'd255 : nb[BYTES_W-1:0];
				asm_phase = PH_RED0;
				asm_partial = '0;
			end
			default: ;
		endcase
		e.red = red_ring[ring_head];
		e.ir = ir_ring[ring_head];
		e.avail = ring_head - ring_tail;
		expected_results.push_back(e);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				predict_unpack(cur_req);
			if (!in_valid || !in_stall) begin
				if (send_gap == 0 && idle_on && $urandom_range(0, 2) == 0)
					send_gap = gap_len();
				if (send_gap == 0 && pending_reqs.size() != 0) begin
					cur_req = pending_reqs.pop_front();
					mode <= cur_req.mode;
					data_byte <= cur_req.data;
					read_pointer <= cur_req.rp;
					write_pointer <= cur_req.wp;
					in_valid <= 1'b1;
				end else begin
					if (send_gap != 0)
						send_gap--;
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result stall
	always @(posedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0)
			stall_left = gap_len();
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic check_field(input string name, input logic [VALUE_W-1:0] want,
			input logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", name, want, got);
			mismatches++;
		end
	endtask

	// result monitor
	always @(posedge clk) begin
		unpack_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				mismatches++;
			end else begin
				e = expected_results.pop_front();
				check_field("sample_done", VALUE_W'(e.done), VALUE_W'(sample_done));
				check_field("latest_red", e.red, latest_red);
				check_field("latest_ir", e.ir, latest_ir);
				check_field("available_count", VALUE_W'(e.avail),
					VALUE_W'(available_count));
				check_field("new_samples", VALUE_W'(e.nsamp), VALUE_W'(new_samples));
				check_field("bytes_to_read", VALUE_W'(e.nbytes), VALUE_W'(bytes_to_read));
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("sensor_fifo_sample_unpacker verification failed");
				$finish;
			end
		end
	end

	task automatic push_req(input logic [1:0] m, input logic [7:0] d,
			input logic [PTR_W-1:0] rp, input logic [PTR_W-1:0] wp);
		sensor_req_t r;
		r.mode = m;
		r.data = d;
		r.rp = rp;
		r.wp = wp;
		pending_reqs.push_back(r);
	endtask

	task automatic push_bytes(input int n);
		repeat (n)
			push_req(MODE_DATA, 8'($urandom_range(0, 255)), PTR_W'($urandom_range(0, 31)),
				PTR_W'($urandom_range(0, 31)));
	endtask

	// pointer pair followed by exactly the bytes it announces
	task automatic push_drain(input int leds);
		int               n;
		logic [PTR_W-1:0] rp;
		n = ($urandom_range(0, 99) < 88) ? $urandom_range(0, 3) : $urandom_range(4, 31);
		rp = PTR_W'($urandom_range(0, 31));
		push_req(MODE_POINTERS, 8'($urandom_range(0, 255)), rp, rp + PTR_W'(n));
		for (int i = 0; i < n; i++) begin
			push_bytes(BYTES_PER_VALUE * leds);
			if ($urandom_range(0, 99) < 35)
				push_req(MODE_ADVANCE, 8'($urandom_range(0, 255)),
					PTR_W'($urandom_range(0, 31)), PTR_W'($urandom_range(0, 31)));
		end
	endtask

	task automatic push_noise();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			push_bytes($urandom_range(1, 5));
		else if (r < 90)
			push_req(MODE_ADVANCE, 8'($urandom_range(0, 255)), PTR_W'($urandom_range(0, 31)),
				PTR_W'($urandom_range(0, 31)));
		else
			push_req(MODE_UNUSED, 8'($urandom_range(0, 255)), PTR_W'($urandom_range(0, 31)),
				PTR_W'($urandom_range(0, 31)));
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_leds(input logic [LEDS_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		leds_reg = val;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	logic [LEDS_W-1:0] led_plan[6] = '{LEDS_RESET, LEDS_RED_ONLY, LEDS_CODE0,
		LEDS_CODE3, LEDS_RED_ONLY, LEDS_RESET};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part, two leds from reset
		push_req(MODE_ADVANCE, 8'h00, 5'd0, 5'd0);
		push_req(MODE_UNUSED, 8'hFF, 5'd31, 5'd31);
		push_req(MODE_POINTERS, 8'h00, 5'd0, 5'd0);
		push_req(MODE_POINTERS, 8'hFF, 5'd0, 5'd31);
		push_req(MODE_POINTERS, 8'h00, 5'd31, 5'd0);
		repeat (3) push_req(MODE_DATA, 8'hFF, 5'd0, 5'd31);
		repeat (3) push_req(MODE_DATA, 8'h00, 5'd31, 5'd0);
		push_req(MODE_DATA, 8'hA5, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h5A, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'hC3, 5'd0, 5'd0);
		wait_idle();
		// switch to red only in the middle of a sample
		write_leds(LEDS_RED_ONLY);
		push_req(MODE_DATA, 8'h12, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h34, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h56, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'hFF, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h00, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'hFF, 5'd0, 5'd0);
		push_req(MODE_ADVANCE, 8'h00, 5'd0, 5'd0);
		push_req(MODE_ADVANCE, 8'h00, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h80, 5'd0, 5'd0);
		push_req(MODE_DATA, 8'h01, 5'd0, 5'd0);
		push_req(MODE_POINTERS, 8'h00, 5'd3, 5'd7);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			write_leds(led_plan[ph]);
			idle_on = (ph != 2);
			while (pending_reqs.size() < PHASE_ITEMS) begin
				if ($urandom_range(0, 99) < 80)
					push_drain((led_plan[ph] == LEDS_RED_ONLY) ? 1 : 2);
				else
					push_noise();
			end
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("sensor_fifo_sample_unpacker verification clean");
		else
			$display("sensor_fifo_sample_unpacker verification failed");
		$finish;
	end

endmodule
